@@ sv/bra_pkg.sv @@
// bra_pkg: shared types, constants and codes for the bitmap run allocator.
// No dependencies; imported by bra_map, bra_scan and bitmap_run_allocator.
package bra_pkg;

    localparam int MAP_BYTES = 64;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int CNT_W     = $clog2(MAP_BYTES + 1);
    localparam int BIT_W     = 9;
    localparam int LEN_W     = 10;
    localparam int BIU_W     = 7;
    localparam int LIMIT_W   = CNT_W + 3;
    localparam int APB_AW    = 2;
    localparam int APB_DW    = 32;

    localparam logic [APB_AW-1:0] REG_BYTES_IN_USE = 2'd0;
    localparam logic [BIU_W-1:0]  BIU_RESET        = 7'd64;

    typedef enum logic [1:0] {
        MODE_TEST  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_SCAN  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BITOP,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        mode_t             mode;
        logic [BIT_W-1:0]  bit_index;
        logic [LEN_W-1:0]  run_length;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  start_index;
        logic              bit_value;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } map_req_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

endpackage

@@ sv/bra_map.sv @@
// bra_map: 64 x 8 usage bitmap memory with per-byte valid bits (reset = free).
// Depends on bra_pkg.
module bra_map (
    input  logic              clk,
    input  logic              rst_n,
    input  bra_pkg::map_req_t req,
    output logic [7:0]        rdata
);
    import bra_pkg::*;

    logic [7:0]           mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] valid_reg;
    logic [7:0]           rdata_reg;
    logic                 rvld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rvld_reg <= valid_reg[req.addr];
            end
        end
    end

    // never-written bytes read as free
    assign rdata = rvld_reg ? rdata_reg : 8'h00;

endmodule

@@ sv/bra_scan.sv @@
// bra_scan: free-run counter fed one map byte (digit) per cycle while ctrl.step is high.
// Depends on bra_pkg.
module bra_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bra_pkg::scan_ctrl_t       ctrl,
    input  logic [7:0]                digit,
    input  logic [bra_pkg::ADDR_W-1:0] byte_pos,
    input  logic [bra_pkg::LEN_W-1:0] want,
    output logic                      hit,
    output logic [bra_pkg::BIT_W-1:0] start_pos
);
    import bra_pkg::*;

    logic [LEN_W-1:0] run_reg;
    logic [LEN_W-1:0] run_next;
    logic [2:0]       hit_off;
    logic [LEN_W-1:0] end_pos;

    // walk the eight bits of the word, stop at the first bit that completes the run
    always_comb
    begin
        logic [LEN_W-1:0] run;
        logic             got;
        logic [2:0]       off;
        run = run_reg;
        got = 1'b0;
        off = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (!got)
            begin
                run = digit[i] ? '0 : run + 1'b1;
                if (run == want)
                begin
                    got = 1'b1;
                    off = 3'(i);
                end
            end
        end
        run_next = run;
        hit      = got;
        hit_off  = off;
    end

    assign end_pos   = LEN_W'({byte_pos, hit_off}) + 1'b1 - want;
    assign start_pos = end_pos[BIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            run_reg <= '0;
        end
        else if (ctrl.step)
        begin
            run_reg <= run_next;
        end
    end

endmodule

@@ sv/bitmap_run_allocator.sv @@
// bitmap_run_allocator: top level, command FSM and APB register for the allocator.
// Depends on bra_pkg, bra_map and bra_scan.
//
// Usage:
//   A command word (mode, bit_index, run_length) is taken when start is high
//   and busy is low. Exactly one result word (found, start_index, bit_value)
//   follows, shown on result for the single cycle in which done is high; the
//   receiver cannot stall, so it must take the word in that cycle.
//   Test, set and clear go from accept through a map read (ST_LOAD), a
//   read-modify-write or bit pick (ST_BITOP) and a result state (ST_DONE).
//   A scan reads the map one byte per cycle until the run is found or
//   bytes_in_use bytes (at most 64) have been walked; a scan that cannot
//   succeed (zero length or longer than the range) goes from ST_LOAD to done.
//   One command is in flight at a time; busy stays high until done.
//   The APB register at address 0 holds bytes_in_use (reset 64, values
//   above 64 act as 64); write it only while busy is low.
//   Reset marks every map bit free at once through per-byte valid flags;
//   no clearing pass is needed and the block is ready right after reset.
module bitmap_run_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bra_pkg::cmd_t              cmd,
    output logic                       done,
    output bra_pkg::res_t              result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bra_pkg::APB_AW-1:0] paddr,
    input  logic [bra_pkg::APB_DW-1:0] pwdata,
    output logic [bra_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import bra_pkg::*;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    res_t              res_reg, res_next;
    logic [BIU_W-1:0]  biu_reg;
    logic              in_range_reg;
    logic              scan_ok_reg;
    logic [CNT_W-1:0]  nbytes_reg;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              rvalid_reg, rvalid_next;
    logic [ADDR_W-1:0] proc_ptr_reg, proc_ptr_next;

    logic              accept;
    logic [CNT_W-1:0]  nbytes;
    logic [LIMIT_W-1:0] limit;
    logic              last_byte;

    map_req_t          map_req;
    logic [7:0]        map_rdata;
    scan_ctrl_t        scan_ctrl;
    logic              scan_hit;
    logic [BIT_W-1:0]  scan_start;
    logic [7:0]        bit_mask;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_BYTES_IN_USE) ? APB_DW'(biu_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            biu_reg <= BIU_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_BYTES_IN_USE))
        begin
            biu_reg <= pwdata[BIU_W-1:0];
        end
    end

    // ---------------- limits ----------------
    assign nbytes = (biu_reg > BIU_W'(MAP_BYTES)) ? CNT_W'(MAP_BYTES) : CNT_W'(biu_reg);
    assign limit  = {nbytes, 3'b000};
    assign accept = start && !busy;

    // ---------------- submodules ----------------
    bra_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rdata (map_rdata)
    );

    bra_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .digit     (map_rdata),
        .byte_pos  (proc_ptr_reg),
        .want      (cmd_reg.run_length),
        .hit       (scan_hit),
        .start_pos (scan_start)
    );

    assign last_byte = (CNT_W'(proc_ptr_reg) + 1'b1) == nbytes_reg;
    assign bit_mask  = 8'(1) << cmd_reg.bit_index[2:0];

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (cmd_reg.mode != MODE_SCAN)
                begin
                    state_next = ST_BITOP;
                end
                else if (scan_ok_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BITOP:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (rvalid_reg && (scan_hit || last_byte))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath control ----------------
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        done          = (state_reg == ST_DONE);
        map_req       = '0;
        scan_ctrl     = '0;
        res_next      = res_reg;
        rd_ptr_next   = rd_ptr_reg;
        rvalid_next   = 1'b0;
        proc_ptr_next = proc_ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_ctrl.clear = 1'b1;
                res_next        = '0;
            end
            ST_LOAD:
            begin
                map_req.rd_en = 1'b1;
                if (cmd_reg.mode == MODE_SCAN)
                begin
                    map_req.addr  = '0;
                    rd_ptr_next   = CNT_W'(1);
                    rvalid_next   = scan_ok_reg;
                    proc_ptr_next = '0;
                end
                else
                begin
                    map_req.addr = cmd_reg.bit_index[BIT_W-1:3];
                end
            end
            ST_BITOP:
            begin
                map_req.addr = cmd_reg.bit_index[BIT_W-1:3];
                if (cmd_reg.mode == MODE_TEST)
                begin
                    res_next.bit_value = in_range_reg & map_rdata[cmd_reg.bit_index[2:0]];
                end
                else
                begin
                    map_req.wr_en = in_range_reg;
                    map_req.wdata = (cmd_reg.mode == MODE_SET) ? (map_rdata | bit_mask)
                                                               : (map_rdata & ~bit_mask);
                end
            end
            ST_SCAN:
            begin
                // read one word ahead of the one being counted
                if (rd_ptr_reg < nbytes_reg)
                begin
                    map_req.rd_en = 1'b1;
                    map_req.addr  = rd_ptr_reg[ADDR_W-1:0];
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                    rvalid_next   = 1'b1;
                end
                if (rvalid_reg)
                begin
                    scan_ctrl.step = 1'b1;
                    proc_ptr_next  = proc_ptr_reg + 1'b1;
                    if (scan_hit)
                    begin
                        res_next.found       = 1'b1;
                        res_next.start_index = scan_start;
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign result = res_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        rd_ptr_reg   <= rd_ptr_next;
        proc_ptr_reg <= proc_ptr_next;
        if (accept)
        begin
            cmd_reg      <= cmd;
            nbytes_reg   <= nbytes;
            in_range_reg <= LIMIT_W'(cmd.bit_index) < limit;
            scan_ok_reg  <= (cmd.run_length != '0) && (LIMIT_W'(cmd.run_length) <= limit);
        end
    end

endmodule
